/* hdl/sliding_window_distinct_pages_defines.svh */
// Assertion macros shared by the working-set monitor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SLIDING_WINDOW_DISTINCT_PAGES_DEFINES_SVH
`define SLIDING_WINDOW_DISTINCT_PAGES_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define SWDP_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SWDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SWDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/swdp_pkg.sv */
// Shared constants, codes and link types for the working-set monitor.
// No dependencies; used by every module of the block.
package swdp_pkg;

  // Sizing
  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned MIN_WINDOW  = 4;
  localparam int unsigned ADDR_BITS   = 48;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned PAGE_SIZE_W = 21;
  localparam int unsigned WIN_W       = 11;
  localparam int unsigned OUT_W       = 11;
  localparam int unsigned CNT_W       = $clog2(MAX_WINDOW + 1);

  // Cell row organization
  localparam int unsigned GROUP_CELLS = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
  localparam int unsigned NUM_GROUPS  = (MAX_WINDOW + GROUP_CELLS - 1) / GROUP_CELLS;
  localparam int unsigned TOTAL_CELLS = NUM_GROUPS * GROUP_CELLS;
  localparam int unsigned IDX_W       = $clog2(TOTAL_CELLS);

  // Divider step counter
  localparam int unsigned DIV_CNT_W = $clog2(ADDR_BITS);

  // Register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Register reset values
  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = PAGE_SIZE_W'(4096);
  localparam logic [WIN_W-1:0]       WIN_SIZE_RST  = WIN_W'(1024);

  typedef enum logic [1:0] {
    REG_PAGE_SIZE   = 2'd0,
    REG_WINDOW_SIZE = 2'd1,
    REG_SKIP_FETCH  = 2'd2
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FETCH  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_MODIFY = 2'd3
  } access_kind_e;

  // Word handed from one cell to the next
  typedef struct packed {
    logic [ADDR_BITS-1:0] page;
    logic                 latest;
  } link_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic                 shift;
    logic [ADDR_BITS-1:0] query;
    logic [CNT_W-1:0]     fill;
    logic [IDX_W-1:0]     oldest;
  } bcast_t;

  // Per-cell or per-group lookup result
  typedef struct packed {
    logic hit;
    logic gone;
  } probe_t;

endpackage

/* hdl/sliding_window_distinct_pages.sv */
// Working-set monitor: for every counted memory access it reports how many distinct pages
// the last window_size counted accesses touched. The page number is the address divided by
// page_size; kind 0 (instruction fetch) accesses are dropped when skip_instruction_fetches
// is set. No result comes while the window is filling after reset or after a window_size
// write. A counted access passes from acceptance through the bit-serial page divider,
// a step that loads the quotient into the query register, a step in which all window
// cells compare the new page and register the grouped lookup results, and a step that
// merges them, shifts the cell row and updates the count; the sequencer then returns to
// idle, where the next word is taken. A dropped fetch leaves the sequencer in idle. The result
// register holds a finished count while the next access is divided; an update that produces
// a result waits only if the previous result has not been taken. There is no clearing pass after reset.
// Depends on swdp_pkg, swdp_div, swdp_group and the shared assertion macro header.
`include "sliding_window_distinct_pages_defines.svh"

module sliding_window_distinct_pages (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // access words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [swdp_pkg::ADDR_BITS-1:0]     address_i,
  input  logic [swdp_pkg::KIND_W-1:0]        access_kind_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [swdp_pkg::OUT_W-1:0]         distinct_count_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swdp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [swdp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [swdp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [swdp_pkg::PAGE_SIZE_W-1:0] page_size_q, page_size_d;
  logic [swdp_pkg::WIN_W-1:0]       win_size_q, win_size_d;
  logic                             skip_q, skip_d;
  logic [swdp_pkg::CNT_W-1:0]       fill_q, fill_d;
  logic [swdp_pkg::CNT_W-1:0]       dist_q, dist_d;
  logic [swdp_pkg::ADDR_BITS-1:0]   query_q, query_d;
  logic                             out_valid_q, out_valid_d;
  logic [swdp_pkg::OUT_W-1:0]       out_count_q, out_count_d;

  logic                             in_fire;
  logic                             skip_item;
  logic                             div_start;
  logic                             div_done;
  logic [swdp_pkg::ADDR_BITS-1:0]   quotient;
  logic [swdp_pkg::PAGE_SIZE_W-1:0] divisor;
  logic                             cfg_wr;
  swdp_pkg::reg_idx_e               cfg_idx;
  logic [swdp_pkg::CNT_W-1:0]       win_eff;
  logic [swdp_pkg::IDX_W-1:0]       win_last;
  logic                             full;
  logic                             upd_go;
  logic                             any_hit;
  logic                             any_gone;
  logic [swdp_pkg::CNT_W-1:0]       dist_upd;
  swdp_pkg::bcast_t                 bcast;
  swdp_pkg::link_t                  link [swdp_pkg::NUM_GROUPS+1];
  swdp_pkg::probe_t                 grp_probe [swdp_pkg::NUM_GROUPS];

  // Input side handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign skip_item  = skip_q && (access_kind_i == swdp_pkg::KIND_FETCH);
  assign div_start  = in_fire && !skip_item;

  // A zero page size divides as one
  assign divisor = (page_size_q == '0) ? swdp_pkg::PAGE_SIZE_W'(1) : page_size_q;

  swdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (address_i),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Clamp the window length into its legal range
  always_comb begin
    if (32'(win_size_q) < swdp_pkg::MIN_WINDOW) begin
      win_eff = swdp_pkg::CNT_W'(swdp_pkg::MIN_WINDOW);
    end else if (32'(win_size_q) > swdp_pkg::MAX_WINDOW) begin
      win_eff = swdp_pkg::CNT_W'(swdp_pkg::MAX_WINDOW);
    end else begin
      win_eff = swdp_pkg::CNT_W'(win_size_q);
    end
  end

  assign win_last = swdp_pkg::IDX_W'(win_eff - swdp_pkg::CNT_W'(1));
  assign full     = !(fill_q < win_eff);
  assign upd_go   = (state_q == ST_UPD) && (!full || !out_valid_q || !out_stall_i);

  // Broadcast to the cell row; the newest page enters at slot zero
  assign bcast   = '{shift: upd_go, query: query_q, fill: fill_q, oldest: win_last};
  assign link[0] = '{page: query_q, latest: 1'b1};

  for (genvar g = 0; g < swdp_pkg::NUM_GROUPS; g++) begin : g_grp
    swdp_group u_group (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .base_i  (swdp_pkg::IDX_W'(g * swdp_pkg::GROUP_CELLS)),
      .bcast_i (bcast),
      .link_i  (link[g]),
      .link_o  (link[g+1]),
      .probe_o (grp_probe[g])
    );
  end

  // Final level of the lookup tree
  always_comb begin
    any_hit  = 1'b0;
    any_gone = 1'b0;
    for (int g = 0; g < swdp_pkg::NUM_GROUPS; g++) begin
      any_hit  = any_hit  | grp_probe[g].hit;
      any_gone = any_gone | grp_probe[g].gone;
    end
  end

  // New page adds one unless seen; evicted page drops one if it was its last copy
  assign dist_upd = dist_q + swdp_pkg::CNT_W'(!any_hit)
                  - swdp_pkg::CNT_W'(any_gone && full);

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = swdp_pkg::reg_idx_e'(paddr[swdp_pkg::APB_ADDR_W-1:2]);

  // Sequencer, counters and register writes
  always_comb begin
    state_d     = state_q;
    page_size_d = page_size_q;
    win_size_d  = win_size_q;
    skip_d      = skip_q;
    fill_d      = fill_q;
    dist_d      = dist_q;
    query_d     = query_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          query_d = quotient;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d = ST_IDLE;
          dist_d  = dist_upd;
          if (!full) begin
            fill_d = fill_q + swdp_pkg::CNT_W'(1);
          end else begin
            out_valid_d = 1'b1;
            out_count_d = swdp_pkg::OUT_W'(dist_upd);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      unique case (cfg_idx)
        swdp_pkg::REG_PAGE_SIZE: begin
          page_size_d = pwdata[swdp_pkg::PAGE_SIZE_W-1:0];
        end
        swdp_pkg::REG_WINDOW_SIZE: begin
          win_size_d = pwdata[swdp_pkg::WIN_W-1:0];
          fill_d     = '0;
          dist_d     = '0;
        end
        swdp_pkg::REG_SKIP_FETCH: begin
          skip_d = pwdata[0];
        end
        default: begin
          skip_d = skip_q;
        end
      endcase
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      page_size_q <= swdp_pkg::PAGE_SIZE_RST;
      win_size_q  <= swdp_pkg::WIN_SIZE_RST;
      skip_q      <= 1'b0;
      fill_q      <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      page_size_q <= page_size_d;
      win_size_q  <= win_size_d;
      skip_q      <= skip_d;
      fill_q      <= fill_d;
      dist_q      <= dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    query_q     <= query_d;
    out_count_q <= out_count_d;
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      swdp_pkg::REG_PAGE_SIZE:   prdata = swdp_pkg::APB_DATA_W'(page_size_q);
      swdp_pkg::REG_WINDOW_SIZE: prdata = swdp_pkg::APB_DATA_W'(win_size_q);
      swdp_pkg::REG_SKIP_FETCH:  prdata = swdp_pkg::APB_DATA_W'(skip_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = out_count_q;

  `SWDP_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= win_eff, "fill count beyond window")
  `SWDP_ASSERT(a_dist_bound, clk_i, rst_ni, dist_q <= fill_q, "distinct count above fill")
  `SWDP_ASSERT_IMP(a_dist_nonzero, clk_i, rst_ni, fill_q != '0, dist_q != '0, "zero count")
  `SWDP_ASSERT_NXT(a_full_result, clk_i, rst_ni, upd_go && full, out_valid_q, "no result")

endmodule

/* hdl/swdp_div.sv */
// Bit-serial restoring divider: address by page size, one quotient bit per cycle.
// Depends on swdp_pkg and the shared assertion macro header.
`include "sliding_window_distinct_pages_defines.svh"

module swdp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [swdp_pkg::ADDR_BITS-1:0]   dividend_i,
  input  logic [swdp_pkg::PAGE_SIZE_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [swdp_pkg::ADDR_BITS-1:0]   quotient_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [swdp_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [swdp_pkg::ADDR_BITS-1:0]   work_q, work_d;
  logic [swdp_pkg::PAGE_SIZE_W-1:0] rem_q, rem_d;
  logic [swdp_pkg::PAGE_SIZE_W-1:0] dsr_q;
  logic [swdp_pkg::PAGE_SIZE_W:0]   rem_sh;
  logic [swdp_pkg::PAGE_SIZE_W:0]   rem_sub;
  logic                             ge;
  logic                             last;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, work_q[swdp_pkg::ADDR_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign rem_d   = ge ? rem_sub[swdp_pkg::PAGE_SIZE_W-1:0]
                      : rem_sh[swdp_pkg::PAGE_SIZE_W-1:0];
  assign work_d  = {work_q[swdp_pkg::ADDR_BITS-2:0], ge};
  assign last    = (cnt_q == swdp_pkg::DIV_CNT_W'(swdp_pkg::ADDR_BITS - 1));

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + swdp_pkg::DIV_CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Load operands, then advance the quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

  `SWDP_ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, !busy_q, "divider started while busy")
  `SWDP_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy_q && !start_i, "done while still stepping")

endmodule

/* hdl/swdp_cell.sv */
// One window slot: holds a page number and its newest-occurrence flag.
// Depends on swdp_pkg for link, broadcast and probe types.
module swdp_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [swdp_pkg::IDX_W-1:0]   idx_i,
  input  swdp_pkg::bcast_t             bcast_i,
  input  swdp_pkg::link_t              link_i,
  output swdp_pkg::link_t              link_o,
  output swdp_pkg::probe_t             probe_o
);

  logic [swdp_pkg::ADDR_BITS-1:0] page_q;
  logic                           latest_q;
  logic                           match;
  logic                           in_win;

  // Compare against the broadcast page; only slots inside the window count
  assign match  = (page_q == bcast_i.query);
  assign in_win = (32'(idx_i) < 32'(bcast_i.fill));

  // A newer copy of this page is entering, so drop the newest flag on the way out
  assign link_o = '{page: page_q, latest: latest_q && !match};

  assign probe_o = '{hit:  match && in_win,
                     gone: (idx_i == bcast_i.oldest) && latest_q && !match};

  // Advance the flag from the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= 1'b0;
    end else if (bcast_i.shift) begin
      latest_q <= link_i.latest;
    end
  end

  // Advance the page from the neighbor
  always_ff @(posedge clk_i) begin
    if (bcast_i.shift) begin
      page_q <= link_i.page;
    end
  end

endmodule

/* hdl/swdp_group.sv */
// A run of chained window cells with a registered OR of their lookup results.
// Depends on swdp_pkg and swdp_cell.
module swdp_group (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [swdp_pkg::IDX_W-1:0] base_i,
  input  swdp_pkg::bcast_t           bcast_i,
  input  swdp_pkg::link_t            link_i,
  output swdp_pkg::link_t            link_o,
  output swdp_pkg::probe_t           probe_o
);

  swdp_pkg::link_t  chain [swdp_pkg::GROUP_CELLS+1];
  swdp_pkg::probe_t cell_probe [swdp_pkg::GROUP_CELLS];
  swdp_pkg::probe_t probe_d, probe_q;

  assign chain[0] = link_i;

  for (genvar c = 0; c < swdp_pkg::GROUP_CELLS; c++) begin : g_cell
    swdp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (base_i | swdp_pkg::IDX_W'(c)),
      .bcast_i (bcast_i),
      .link_i  (chain[c]),
      .link_o  (chain[c+1]),
      .probe_o (cell_probe[c])
    );
  end

  assign link_o = chain[swdp_pkg::GROUP_CELLS];

  // Merge the cell results of this run
  always_comb begin
    probe_d = '0;
    for (int c = 0; c < swdp_pkg::GROUP_CELLS; c++) begin
      probe_d.hit  = probe_d.hit  | cell_probe[c].hit;
      probe_d.gone = probe_d.gone | cell_probe[c].gone;
    end
  end

  // Hold the merged result for the top-level reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule
